// ===== hw/rtl/mvsm_pkg.sv =====
// Shared types and constants of the multi-voice sample mixer.
// Used by the mixer top level and by its port checker; no dependencies.
package mvsm_pkg;

  localparam logic [8:0] GAIN_ONE   = 9'd256;
  localparam logic [8:0] MUSIC_TRIM = 9'd192;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_VOICE = 2'd1,
    REQ_MUSIC = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    KIND_LOAD   = 3'd0,
    KIND_VOICE  = 3'd1,
    KIND_NOFREE = 3'd2,
    KIND_MUSIC  = 3'd3,
    KIND_FRAME  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CFG_MASTER = 2'd0,
    CFG_MUSIC  = 2'd1,
    CFG_BLOCKS = 2'd2,
    CFG_PLAYER = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CAT_PLAYER = 2'd0,
    CAT_BLOCKS = 2'd1,
    CAT_UI     = 2'd2,
    CAT_SPARE  = 2'd3
  } cat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_VRD,
    ST_VCHK,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_ACC,
    ST_MUS,
    ST_FIN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [15:0] base;
    logic [16:0] len;
    logic [16:0] pos;
    logic [8:0]  gain;
    logic [1:0]  cat;
  } voice_t;

endpackage

// ===== hw/rtl/multi_voice_sample_mixer.sv =====
// Multi-voice sample mixer: sample memory, voice table and one shared multiplier.
// Depends on mvsm_pkg.
// A voice start scans for a free voice, one voice per cycle; a frame reads each
// voice in turn and mixes each playing voice, then the music if it plays. The
// single multiplier runs three passes per playing source. One request at a time;
// the next request is taken in the cycle after the result strobe. Reset clears
// voice and music activity and sets the master, music, blocks and player gains to
// unity; sample memory is not cleared. Results cannot be stalled by the receiver.
module multi_voice_sample_mixer #(
  parameter int NUM_VOICES   = 32,
  parameter int SAMPLE_WORDS = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [15:0]        in_address,
  input  logic signed [15:0] in_sample_word,
  input  logic [16:0]        in_sound_length,
  input  logic [8:0]         in_voice_volume,
  input  logic [1:0]         in_category,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_wdata,
  output logic               out_valid,
  output logic [2:0]         out_result_kind,
  output logic [4:0]         out_voice_index,
  output logic signed [15:0] out_left_sample,
  output logic signed [15:0] out_right_sample
);

  localparam int VW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int AW    = $clog2(SAMPLE_WORDS);
  localparam int SW    = (AW > 18) ? AW : 18;
  localparam int PW    = 44;
  localparam int ACC_W = 42 + $clog2(NUM_VOICES + 1);
  localparam logic [VW-1:0] LAST_V = VW'(NUM_VOICES - 1);
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd8388608);
  localparam logic signed [ACC_W-1:0] MAXV = ACC_W'(64'sd32767);
  localparam logic signed [ACC_W-1:0] MINV = ACC_W'(-64'sd32768);

  mvsm_pkg::state_t state_r, state_nxt;

  logic [NUM_VOICES-1:0] vbusy_r;
  logic                  music_busy_r;
  logic [15:0]           music_base_r;
  logic [16:0]           music_len_r, music_pos_r;
  logic [8:0]            master_r, musg_r, blocks_r, player_r;
  logic [8:0]            cfg_sat;

  mvsm_pkg::voice_t vmem [NUM_VOICES];
  mvsm_pkg::voice_t vrd_r, vmem_wdata;
  logic signed [15:0] smem [SAMPLE_WORDS];
  logic signed [15:0] srd_r;

  logic [VW-1:0]  vcnt_r;
  logic           music_phase_r;
  logic [15:0]    addr_r;
  logic [16:0]    len_r;
  logic [8:0]     vol_r;
  logic [1:0]     cat_r;
  logic [8:0]     g1_r, g2_r, g3_r;
  logic signed [PW-1:0]    prod_r, mul_a, prod_nxt;
  logic [8:0]              mul_b;
  logic signed [ACC_W-1:0] acc_r, acc_t, acc_sh;
  mvsm_pkg::kind_t kind_r;
  logic [VW-1:0]   idx_r;
  logic [VW+4:0]   idx_ext;
  logic signed [15:0] mix_r;

  logic          accept, last, v_busy, v_play, m_play, claim, vmem_we, smem_re;
  logic [17:0]   sum18;
  logic [SW-1:0] sum_ext, ld_ext;
  logic [AW-1:0] saddr, laddr;
  logic [8:0]    cat_gain;

  assign accept = start && !busy;
  assign last   = (vcnt_r == LAST_V);
  assign v_busy = vbusy_r[vcnt_r];
  assign m_play = music_busy_r && (music_pos_r < music_len_r);
  assign cfg_sat = (cfg_wdata > mvsm_pkg::GAIN_ONE) ? mvsm_pkg::GAIN_ONE : cfg_wdata;

  always_comb begin
    unique case (mvsm_pkg::cat_t'(vrd_r.cat))
      mvsm_pkg::CAT_PLAYER: cat_gain = player_r;
      mvsm_pkg::CAT_BLOCKS: cat_gain = blocks_r;
      default:              cat_gain = mvsm_pkg::GAIN_ONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mvsm_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mvsm_pkg::req_t'(in_req_type))
            mvsm_pkg::REQ_VOICE: state_nxt = mvsm_pkg::ST_SCAN;
            mvsm_pkg::REQ_TICK:  state_nxt = mvsm_pkg::ST_VRD;
            default:             state_nxt = mvsm_pkg::ST_RESP;
          endcase
        end
      end
      mvsm_pkg::ST_SCAN: begin
        if (!v_busy || last) state_nxt = mvsm_pkg::ST_RESP;
      end
      mvsm_pkg::ST_VRD: state_nxt = mvsm_pkg::ST_VCHK;
      mvsm_pkg::ST_VCHK: begin
        if (v_play) state_nxt = mvsm_pkg::ST_M1;
        else if (last) state_nxt = mvsm_pkg::ST_MUS;
        else state_nxt = mvsm_pkg::ST_VRD;
      end
      mvsm_pkg::ST_M1: state_nxt = mvsm_pkg::ST_M2;
      mvsm_pkg::ST_M2: state_nxt = mvsm_pkg::ST_M3;
      mvsm_pkg::ST_M3: state_nxt = mvsm_pkg::ST_ACC;
      mvsm_pkg::ST_ACC: begin
        if (music_phase_r) state_nxt = mvsm_pkg::ST_FIN;
        else if (last) state_nxt = mvsm_pkg::ST_MUS;
        else state_nxt = mvsm_pkg::ST_VRD;
      end
      mvsm_pkg::ST_MUS: state_nxt = m_play ? mvsm_pkg::ST_M1 : mvsm_pkg::ST_FIN;
      mvsm_pkg::ST_FIN: state_nxt = mvsm_pkg::ST_RESP;
      mvsm_pkg::ST_RESP: state_nxt = mvsm_pkg::ST_IDLE;
      default: state_nxt = mvsm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != mvsm_pkg::ST_IDLE);
    out_valid = (state_r == mvsm_pkg::ST_RESP);
    claim     = (state_r == mvsm_pkg::ST_SCAN) && !v_busy;
    v_play    = (state_r == mvsm_pkg::ST_VCHK) && v_busy && (vrd_r.pos < vrd_r.len);
    vmem_we   = claim || v_play;
    smem_re   = v_play || ((state_r == mvsm_pkg::ST_MUS) && m_play);
    if (claim) begin
      vmem_wdata = '{base: addr_r, len: len_r, pos: 17'd0, gain: vol_r, cat: cat_r};
    end else begin
      vmem_wdata     = vrd_r;
      vmem_wdata.pos = vrd_r.pos + 17'd1;
    end
    if (state_r == mvsm_pkg::ST_MUS) begin
      sum18 = {2'b00, music_base_r} + {1'b0, music_pos_r};
    end else begin
      sum18 = {2'b00, vrd_r.base} + {1'b0, vrd_r.pos};
    end
    sum_ext = SW'(sum18);
    saddr   = sum_ext[AW-1:0];
    ld_ext  = SW'(in_address);
    laddr   = ld_ext[AW-1:0];
    unique case (state_r)
      mvsm_pkg::ST_M1: begin
        mul_a = PW'(srd_r);
        mul_b = g1_r;
      end
      mvsm_pkg::ST_M2: begin
        mul_a = prod_r;
        mul_b = g2_r;
      end
      default: begin
        mul_a = prod_r;
        mul_b = g3_r;
      end
    endcase
    prod_nxt = PW'(mul_a * $signed({1'b0, mul_b}));
    acc_t    = acc_r + HALF;
    acc_sh   = acc_t >>> 24;
    idx_ext  = {5'b00000, idx_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mvsm_pkg::ST_IDLE;
      vbusy_r      <= '0;
      music_busy_r <= 1'b0;
      master_r     <= mvsm_pkg::GAIN_ONE;
      musg_r       <= mvsm_pkg::GAIN_ONE;
      blocks_r     <= mvsm_pkg::GAIN_ONE;
      player_r     <= mvsm_pkg::GAIN_ONE;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (mvsm_pkg::cfg_idx_t'(cfg_index))
          mvsm_pkg::CFG_MASTER: master_r <= cfg_sat;
          mvsm_pkg::CFG_MUSIC:  musg_r   <= cfg_sat;
          mvsm_pkg::CFG_BLOCKS: blocks_r <= cfg_sat;
          mvsm_pkg::CFG_PLAYER: player_r <= cfg_sat;
          default: ;
        endcase
      end
      if (accept && (in_req_type == mvsm_pkg::REQ_MUSIC)) music_busy_r <= 1'b1;
      if ((state_r == mvsm_pkg::ST_MUS) && music_busy_r && !m_play) music_busy_r <= 1'b0;
      if (claim) vbusy_r[vcnt_r] <= 1'b1;
      if ((state_r == mvsm_pkg::ST_VCHK) && v_busy && !v_play) vbusy_r[vcnt_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    vrd_r <= vmem[vcnt_r];
    if (vmem_we) vmem[vcnt_r] <= vmem_wdata;
  end

  always_ff @(posedge clk) begin
    if (accept && (in_req_type == mvsm_pkg::REQ_LOAD)) smem[laddr] <= in_sample_word;
    if (smem_re) srd_r <= smem[saddr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r        <= in_address;
      len_r         <= in_sound_length;
      vol_r         <= in_voice_volume;
      cat_r         <= in_category;
      vcnt_r        <= '0;
      idx_r         <= '0;
      acc_r         <= '0;
      mix_r         <= '0;
      music_phase_r <= 1'b0;
      unique case (mvsm_pkg::req_t'(in_req_type))
        mvsm_pkg::REQ_LOAD:  kind_r <= mvsm_pkg::KIND_LOAD;
        mvsm_pkg::REQ_VOICE: kind_r <= mvsm_pkg::KIND_NOFREE;
        mvsm_pkg::REQ_MUSIC: kind_r <= mvsm_pkg::KIND_MUSIC;
        default:             kind_r <= mvsm_pkg::KIND_FRAME;
      endcase
      if (in_req_type == mvsm_pkg::REQ_MUSIC) begin
        music_base_r <= in_address;
        music_len_r  <= in_sound_length;
        music_pos_r  <= '0;
      end
    end
    if (claim) begin
      kind_r <= mvsm_pkg::KIND_VOICE;
      idx_r  <= vcnt_r;
    end
    if ((state_r == mvsm_pkg::ST_SCAN) && v_busy && !last) vcnt_r <= vcnt_r + 1'b1;
    if ((state_r == mvsm_pkg::ST_VCHK) && !v_play && !last) vcnt_r <= vcnt_r + 1'b1;
    if ((state_r == mvsm_pkg::ST_ACC) && !music_phase_r && !last) vcnt_r <= vcnt_r + 1'b1;
    if (v_play) begin
      g1_r <= vrd_r.gain;
      g2_r <= cat_gain;
      g3_r <= master_r;
    end
    if ((state_r == mvsm_pkg::ST_MUS) && m_play) begin
      g1_r          <= musg_r;
      g2_r          <= master_r;
      g3_r          <= mvsm_pkg::MUSIC_TRIM;
      music_pos_r   <= music_pos_r + 17'd1;
      music_phase_r <= 1'b1;
    end
    if ((state_r == mvsm_pkg::ST_M1) || (state_r == mvsm_pkg::ST_M2) ||
        (state_r == mvsm_pkg::ST_M3)) begin
      prod_r <= prod_nxt;
    end
    if (state_r == mvsm_pkg::ST_ACC) acc_r <= acc_r + ACC_W'(prod_r);
    if (state_r == mvsm_pkg::ST_FIN) begin
      if (acc_sh > MAXV) mix_r <= 16'sh7FFF;
      else if (acc_sh < MINV) mix_r <= -16'sh8000;
      else mix_r <= acc_sh[15:0];
    end
  end

  assign out_result_kind  = kind_r;
  assign out_voice_index  = idx_ext[4:0];
  assign out_left_sample  = mix_r;
  assign out_right_sample = mix_r;

endmodule

// ===== hw/rtl/mvsm_checker.sv =====
// Port-level checker for the multi-voice sample mixer, bound to the top level.
// Depends on mvsm_pkg and multi_voice_sample_mixer.
module mvsm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic [2:0]         out_result_kind,
  input logic signed [15:0] out_left_sample,
  input logic signed [15:0] out_right_sample
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a request");

  a_request_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted request did not start work");

  a_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_sample == out_right_sample)) else $error("channels differ");

  a_quiet_nonframe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind != mvsm_pkg::KIND_FRAME)) |-> (out_left_sample == 16'sd0))
    else $error("nonzero sample on a non-frame result");

endmodule

bind multi_voice_sample_mixer mvsm_checker u_mvsm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_result_kind  (out_result_kind),
  .out_left_sample  (out_left_sample),
  .out_right_sample (out_right_sample)
);
